[rtl/pgacc_pkg.sv]
// Shared types, constants and register codes of the pressure-gradient accumulator.
package pgacc_pkg;

	localparam int FRACTION_BITS_DEFAULT = 16;

	localparam int REG_W = 31;
	localparam int FIELD_W = 32;
	localparam int IDX_W = 2;

	localparam logic [IDX_W-1:0] REG_SMOOTHING_LENGTH         = 2'd0;
	localparam logic [IDX_W-1:0] REG_INVERSE_SMOOTHING_LENGTH = 2'd1;
	localparam logic [IDX_W-1:0] REG_GRADIENT_SCALE           = 2'd2;
	localparam logic [IDX_W-1:0] REG_PARTICLE_MASS            = 2'd3;

	localparam logic [REG_W-1:0] RST_SMOOTHING_LENGTH         = 31'd65536;
	localparam logic [REG_W-1:0] RST_INVERSE_SMOOTHING_LENGTH = 31'd65536;
	localparam logic [REG_W-1:0] RST_GRADIENT_SCALE           = 31'd1003217;
	localparam logic [REG_W-1:0] RST_PARTICLE_MASS            = 31'd65536;

	localparam int DIVIDEND_W = 64;
	localparam int DIVISOR_W = 32;

	typedef struct packed {
		logic                  start;
		logic [DIVIDEND_W-1:0] dividend;
		logic [DIVISOR_W-1:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic                  done;
		logic                  busy;
		logic [DIVIDEND_W-1:0] quotient;
	} div_rsp_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_SQ,
		ST_SQ_ACC,
		ST_SQRT,
		ST_SQRT_WAIT,
		ST_Q,
		ST_Q_ACC,
		ST_MAG,
		ST_MAG_ACC,
		ST_W,
		ST_W_ACC,
		ST_PD1,
		ST_PD1_WAIT,
		ST_PD2,
		ST_PD2_WAIT,
		ST_CO,
		ST_CO_ACC,
		ST_G,
		ST_G_DIV,
		ST_G_WAIT,
		ST_GM,
		ST_GM_ACC,
		ST_FIN
	} state_t;

endpackage

[rtl/pgacc_mul.sv]
// Shared registered multiplier of the accumulator datapath.
module pgacc_mul (
	input  logic        clk,
	input  logic [32:0] a,
	input  logic [31:0] b,
	output logic [63:0] prod
);

	logic [64:0] full;
	logic [63:0] prod_q;

	assign full = {32'd0, a} * {33'd0, b};

	always_ff @(posedge clk) begin
		prod_q <= full[63:0];
	end

	assign prod = prod_q;

endmodule

[rtl/pgacc_div.sv]
// Restoring unsigned divider, one quotient bit per cycle.
module pgacc_div (
	input  logic                clk,
	input  logic                arst_n,
	input  pgacc_pkg::div_req_t req,
	output pgacc_pkg::div_rsp_t rsp
);

	localparam int N = pgacc_pkg::DIVIDEND_W;
	localparam int D = pgacc_pkg::DIVISOR_W;
	localparam int CW = $clog2(N);

	logic [N-1:0]  quot_q;
	logic [D-1:0]  rem_q;
	logic [D-1:0]  div_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [D:0]    rem_sh;
	logic [D:0]    rem_sub;
	logic          ge;

	assign rem_sh = {rem_q, quot_q[N-1]};
	assign rem_sub = rem_sh - {1'b0, div_q};
	assign ge = rem_sh >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CW'(N - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quot_q <= req.dividend;
			rem_q <= '0;
			div_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= ge ? rem_sub[D-1:0] : rem_sh[D-1:0];
			quot_q <= {quot_q[N-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.busy = busy_q;
	assign rsp.quotient = quot_q;

endmodule

[rtl/pgacc_sqrt.sv]
// Digit-by-digit integer square root, one root bit per cycle.
module pgacc_sqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] value,
	output logic        done,
	output logic [31:0] root
);

	logic [63:0] val_q;
	logic [33:0] rem_q;
	logic [31:0] root_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [34:0] rem_sh;
	logic [34:0] trial;
	logic [34:0] rem_sub;
	logic        ge;

	assign rem_sh = {rem_q[32:0], val_q[63:62]};
	assign trial = {1'b0, root_q, 2'b01};
	assign rem_sub = rem_sh - trial;
	assign ge = rem_sh >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == 5'd31) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			val_q <= value;
			rem_q <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			val_q <= {val_q[61:0], 2'b00};
			rem_q <= ge ? rem_sub[33:0] : rem_sh[33:0];
			root_q <= {root_q[30:0], ge};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

[rtl/sph_pressure_gradient_accumulator_core.sv]
// Top level of the pressure-gradient accumulator: sequencer, registers and datapath.
// Takes one neighbor record per request and adds its symmetric pressure force, built
// from the cubic-spline kernel gradient, into a three-component accumulator; the
// request marked last returns the saturated Q16.16 acceleration and clears the sum.
// A record that contributes holds the block from one accept to the next through the
// square-root unit, two or four divisions for the two pressure terms and three for
// the gradient components on the shared 64-step divider, plus short multiplier
// steps. A record skipped at accept goes straight to the final state. A record whose
// distance is zero or beyond the support leaves after the square root. A pending
// result under out_stall holds the block in its final state when the record is
// marked last. in_stall is high whenever a record is in work.
module sph_pressure_gradient_accumulator_core #(
	parameter int FRACTION_BITS = pgacc_pkg::FRACTION_BITS_DEFAULT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_index,
	input  logic [30:0]           cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic signed [31:0]    offset_x,
	input  logic signed [31:0]    offset_y,
	input  logic signed [31:0]    offset_z,
	input  logic signed [31:0]    own_density,
	input  logic signed [31:0]    own_pressure,
	input  logic signed [31:0]    neighbor_density,
	input  logic signed [31:0]    neighbor_pressure,
	input  logic                  neighbor_present,
	input  logic                  last_neighbor,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic signed [31:0]    accel_x,
	output logic signed [31:0]    accel_y,
	output logic signed [31:0]    accel_z,
	output logic                  particle_skipped,
	output logic                  saturated
);

	localparam int QW = FRACTION_BITS + 1;
	localparam logic [63:0] ONE = 64'd1 << FRACTION_BITS;
	localparam logic [QW-1:0] ONE_Q = QW'(1) << FRACTION_BITS;
	localparam logic [QW-1:0] HALF_Q = QW'(1) << (FRACTION_BITS - 1);
	localparam int THR_SHIFT = 31 - FRACTION_BITS;

	pgacc_pkg::state_t state_q, state_d;

	logic [30:0] h_q, invh_q, gs_q, mass_q;

	logic [31:0]        off_mag_q [3];
	logic [2:0]         off_neg_q;
	logic signed [31:0] rho_i_q, p_i_q, rho_j_q, p_j_q;
	logic               last_q, skip_q;
	logic [1:0]         cnt_q;
	logic               pk_q;
	logic [63:0]        r2_q;
	logic [31:0]        rl_q;
	logic [QW-1:0]      q_q;
	logic [31:0]        mag_q;
	logic [31:0]        w_q;
	logic [63:0]        q1_q;
	logic signed [31:0] term_q [2];
	logic [31:0]        coeff_mag_q;
	logic               coeff_neg_q;
	logic [31:0]        gm_q;
	logic signed [63:0] acc_q [3];

	logic               out_valid_q;
	logic signed [31:0] out_q [3];
	logic               out_skip_q, out_sat_q;

	logic [32:0]         mul_a;
	logic [31:0]         mul_b;
	logic [63:0]         prod;
	pgacc_pkg::div_req_t div_req;
	pgacc_pkg::div_rsp_t div_rsp;
	logic                sqrt_start;
	logic                sqrt_done;
	logic [31:0]         sqrt_root;

	logic               accept;
	logic               out_free;
	logic signed [31:0] p_sel, rho_sel;
	logic [31:0]        p_mag;
	logic [63:0]        thr;
	logic               big;
	logic [32:0]        tsum;
	logic [32:0]        tsum_mag;
	logic [63:0]        prod_sh;
	logic [31:0]        two_minus;
	logic [QW-1:0]      one_minus;

	assign accept = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = state_q != pgacc_pkg::ST_IDLE;

	assign p_sel = pk_q ? p_j_q : p_i_q;
	assign rho_sel = pk_q ? rho_j_q : rho_i_q;
	assign p_mag = p_sel[31] ? 32'(-p_sel) : 32'(p_sel);
	assign thr = {32'd0, rho_sel} << THR_SHIFT;
	assign big = div_rsp.quotient >= thr;
	assign tsum = {term_q[0][31], term_q[0]} + {term_q[1][31], term_q[1]};
	assign tsum_mag = tsum[32] ? (33'd0 - tsum) : tsum;
	assign prod_sh = prod >> FRACTION_BITS;
	assign two_minus = (32'd2 << FRACTION_BITS) - 32'd3 * 32'(q_q);
	assign one_minus = ONE_Q - q_q;

	pgacc_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	pgacc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	pgacc_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sqrt_start),
		.value  (r2_q),
		.done   (sqrt_done),
		.root   (sqrt_root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q <= pgacc_pkg::RST_SMOOTHING_LENGTH;
			invh_q <= pgacc_pkg::RST_INVERSE_SMOOTHING_LENGTH;
			gs_q <= pgacc_pkg::RST_GRADIENT_SCALE;
			mass_q <= pgacc_pkg::RST_PARTICLE_MASS;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pgacc_pkg::REG_SMOOTHING_LENGTH: h_q <= cfg_data;
				pgacc_pkg::REG_INVERSE_SMOOTHING_LENGTH: invh_q <= cfg_data;
				pgacc_pkg::REG_GRADIENT_SCALE: gs_q <= cfg_data;
				pgacc_pkg::REG_PARTICLE_MASS: mass_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pgacc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		mul_a = '0;
		mul_b = '0;
		div_req.start = 1'b0;
		div_req.dividend = '0;
		div_req.divisor = '0;
		sqrt_start = 1'b0;
		unique case (state_q)
			pgacc_pkg::ST_IDLE: begin
				if (accept) begin
					if (neighbor_present && own_density > 0 && neighbor_density > 0) begin
						state_d = pgacc_pkg::ST_SQ;
					end else begin
						state_d = pgacc_pkg::ST_FIN;
					end
				end
			end
			pgacc_pkg::ST_SQ: begin
				mul_a = {1'b0, off_mag_q[cnt_q]};
				mul_b = off_mag_q[cnt_q];
				state_d = pgacc_pkg::ST_SQ_ACC;
			end
			pgacc_pkg::ST_SQ_ACC: begin
				state_d = (cnt_q == 2'd2) ? pgacc_pkg::ST_SQRT : pgacc_pkg::ST_SQ;
			end
			pgacc_pkg::ST_SQRT: begin
				sqrt_start = 1'b1;
				state_d = pgacc_pkg::ST_SQRT_WAIT;
			end
			pgacc_pkg::ST_SQRT_WAIT: begin
				if (sqrt_done) begin
					if (sqrt_root == 32'd0 || sqrt_root > {1'b0, h_q}) begin
						state_d = pgacc_pkg::ST_FIN;
					end else begin
						state_d = pgacc_pkg::ST_Q;
					end
				end
			end
			pgacc_pkg::ST_Q: begin
				mul_a = {1'b0, rl_q};
				mul_b = {1'b0, invh_q};
				state_d = pgacc_pkg::ST_Q_ACC;
			end
			pgacc_pkg::ST_Q_ACC: state_d = pgacc_pkg::ST_MAG;
			pgacc_pkg::ST_MAG: begin
				if (q_q <= HALF_Q) begin
					mul_a = 33'(q_q);
					mul_b = two_minus;
				end else begin
					mul_a = 33'(one_minus);
					mul_b = 32'(one_minus);
				end
				state_d = pgacc_pkg::ST_MAG_ACC;
			end
			pgacc_pkg::ST_MAG_ACC: state_d = pgacc_pkg::ST_W;
			pgacc_pkg::ST_W: begin
				mul_a = {2'b0, gs_q};
				mul_b = mag_q;
				state_d = pgacc_pkg::ST_W_ACC;
			end
			pgacc_pkg::ST_W_ACC: state_d = pgacc_pkg::ST_PD1;
			pgacc_pkg::ST_PD1: begin
				div_req.start = 1'b1;
				div_req.dividend = {32'd0, p_mag} << FRACTION_BITS;
				div_req.divisor = rho_sel;
				state_d = pgacc_pkg::ST_PD1_WAIT;
			end
			pgacc_pkg::ST_PD1_WAIT: begin
				if (div_rsp.done) begin
					if (big) begin
						state_d = pk_q ? pgacc_pkg::ST_CO : pgacc_pkg::ST_PD1;
					end else begin
						state_d = pgacc_pkg::ST_PD2;
					end
				end
			end
			pgacc_pkg::ST_PD2: begin
				div_req.start = 1'b1;
				div_req.dividend = q1_q << FRACTION_BITS;
				div_req.divisor = rho_sel;
				state_d = pgacc_pkg::ST_PD2_WAIT;
			end
			pgacc_pkg::ST_PD2_WAIT: begin
				if (div_rsp.done) begin
					state_d = pk_q ? pgacc_pkg::ST_CO : pgacc_pkg::ST_PD1;
				end
			end
			pgacc_pkg::ST_CO: begin
				mul_a = tsum_mag;
				mul_b = {1'b0, mass_q};
				state_d = pgacc_pkg::ST_CO_ACC;
			end
			pgacc_pkg::ST_CO_ACC: state_d = pgacc_pkg::ST_G;
			pgacc_pkg::ST_G: begin
				mul_a = {1'b0, w_q};
				mul_b = off_mag_q[cnt_q];
				state_d = pgacc_pkg::ST_G_DIV;
			end
			pgacc_pkg::ST_G_DIV: begin
				div_req.start = 1'b1;
				div_req.dividend = prod;
				div_req.divisor = rl_q;
				state_d = pgacc_pkg::ST_G_WAIT;
			end
			pgacc_pkg::ST_G_WAIT: begin
				if (div_rsp.done) begin
					state_d = pgacc_pkg::ST_GM;
				end
			end
			pgacc_pkg::ST_GM: begin
				mul_a = {1'b0, coeff_mag_q};
				mul_b = gm_q;
				state_d = pgacc_pkg::ST_GM_ACC;
			end
			pgacc_pkg::ST_GM_ACC: begin
				state_d = (cnt_q == 2'd2) ? pgacc_pkg::ST_FIN : pgacc_pkg::ST_G;
			end
			pgacc_pkg::ST_FIN: begin
				if (!last_q || out_free) begin
					state_d = pgacc_pkg::ST_IDLE;
				end
			end
			default: state_d = pgacc_pkg::ST_IDLE;
		endcase
	end

	logic [64:0] contrib;
	logic [64:0] acc_sum;
	logic [63:0] acc_next;

	assign contrib = (coeff_neg_q ^ off_neg_q[cnt_q]) ? (65'd0 - {1'b0, prod_sh})
		: {1'b0, prod_sh};
	assign acc_sum = {acc_q[cnt_q][63], acc_q[cnt_q]} + contrib;
	assign acc_next = (acc_sum[64] != acc_sum[63])
		? (acc_sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}}) : acc_sum[63:0];

	always_ff @(posedge clk) begin
		unique case (state_q)
			pgacc_pkg::ST_IDLE: begin
				if (accept) begin
					off_mag_q[0] <= offset_x[31] ? 32'(-offset_x) : 32'(offset_x);
					off_mag_q[1] <= offset_y[31] ? 32'(-offset_y) : 32'(offset_y);
					off_mag_q[2] <= offset_z[31] ? 32'(-offset_z) : 32'(offset_z);
					off_neg_q <= {offset_z[31], offset_y[31], offset_x[31]};
					rho_i_q <= own_density;
					p_i_q <= own_pressure;
					rho_j_q <= neighbor_density;
					p_j_q <= neighbor_pressure;
					last_q <= last_neighbor;
					skip_q <= !(own_density > 0);
					r2_q <= '0;
				end
			end
			pgacc_pkg::ST_SQ_ACC: r2_q <= r2_q + prod;
			pgacc_pkg::ST_SQRT_WAIT: begin
				if (sqrt_done) begin
					rl_q <= sqrt_root;
				end
			end
			pgacc_pkg::ST_Q_ACC: q_q <= (prod_sh > ONE) ? ONE_Q : prod_sh[QW-1:0];
			pgacc_pkg::ST_MAG_ACC: mag_q <= prod_sh[31:0];
			pgacc_pkg::ST_W_ACC: w_q <= prod_sh[31:0];
			pgacc_pkg::ST_PD1_WAIT: begin
				if (div_rsp.done) begin
					if (big) begin
						term_q[pk_q] <= p_sel[31] ? 32'sh80000000 : 32'sh7fffffff;
					end else begin
						q1_q <= div_rsp.quotient;
					end
				end
			end
			pgacc_pkg::ST_PD2_WAIT: begin
				if (div_rsp.done) begin
					if (p_sel[31]) begin
						term_q[pk_q] <= (div_rsp.quotient >= 64'h80000000) ? 32'sh80000000
							: 32'(-div_rsp.quotient[31:0]);
					end else begin
						term_q[pk_q] <= (div_rsp.quotient >= 64'h7fffffff) ? 32'sh7fffffff
							: div_rsp.quotient[31:0];
					end
				end
			end
			pgacc_pkg::ST_CO_ACC: begin
				coeff_neg_q <= tsum[32];
				if (tsum[32]) begin
					coeff_mag_q <= (prod_sh >= 64'h80000000) ? 32'h80000000 : prod_sh[31:0];
				end else begin
					coeff_mag_q <= (prod_sh >= 64'h7fffffff) ? 32'h7fffffff : prod_sh[31:0];
				end
			end
			pgacc_pkg::ST_G_WAIT: begin
				if (div_rsp.done) begin
					gm_q <= div_rsp.quotient[31:0];
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			pk_q <= 1'b0;
			acc_q[0] <= '0;
			acc_q[1] <= '0;
			acc_q[2] <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == pgacc_pkg::ST_FIN && last_q && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				pgacc_pkg::ST_IDLE: begin
					cnt_q <= '0;
					pk_q <= 1'b0;
				end
				pgacc_pkg::ST_SQ_ACC: cnt_q <= (cnt_q == 2'd2) ? 2'd0 : cnt_q + 2'd1;
				pgacc_pkg::ST_PD1_WAIT: begin
					if (div_rsp.done && big) begin
						pk_q <= !pk_q;
					end
				end
				pgacc_pkg::ST_PD2_WAIT: begin
					if (div_rsp.done) begin
						pk_q <= !pk_q;
					end
				end
				pgacc_pkg::ST_GM_ACC: begin
					acc_q[cnt_q] <= acc_next;
					cnt_q <= (cnt_q == 2'd2) ? 2'd0 : cnt_q + 2'd1;
				end
				pgacc_pkg::ST_FIN: begin
					if (last_q && out_free) begin
						acc_q[0] <= '0;
						acc_q[1] <= '0;
						acc_q[2] <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	logic [2:0]         fits;
	logic signed [31:0] clip [3];

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			fits[c] = (acc_q[c][63:31] == {33{1'b0}}) || (acc_q[c][63:31] == {33{1'b1}});
			if (fits[c]) begin
				clip[c] = acc_q[c][31:0];
			end else begin
				clip[c] = acc_q[c][63] ? 32'sh80000000 : 32'sh7fffffff;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == pgacc_pkg::ST_FIN && last_q && out_free) begin
			for (int c = 0; c < 3; c++) begin
				out_q[c] <= skip_q ? 32'sd0 : clip[c];
			end
			out_skip_q <= skip_q;
			out_sat_q <= !skip_q && (fits != 3'b111);
		end
	end

	assign out_valid = out_valid_q;
	assign accel_x = out_q[0];
	assign accel_y = out_q[1];
	assign accel_z = out_q[2];
	assign particle_skipped = out_skip_q;
	assign saturated = out_sat_q;

`ifndef ASSERT_OFF
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> in_stall)
		else $error("record accepted but block not busy");

	a_skip_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && particle_skipped) |->
		(accel_x == 0 && accel_y == 0 && accel_z == 0 && !saturated))
		else $error("skipped particle with nonzero result");

	a_div_idle_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_rsp.busy)
		else $error("divider restarted while busy");

	a_emit_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pgacc_pkg::ST_FIN && last_q && out_free) |=>
		(out_valid && acc_q[0] == 0 && acc_q[1] == 0 && acc_q[2] == 0))
		else $error("result not posted or accumulator not cleared");
`endif

endmodule
